### rtl/core/itr_pkg.sv
// itr_pkg: shared types, constants and helpers for integer_to_radix_digits
// used by the controller, the datapath and the top level
package itr_pkg;

  localparam int MAX_DIGITS = 63;
  localparam int VALUE_W    = 64;
  localparam int MAG_W      = VALUE_W - 1;
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int DADDR_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int BITCNT_W   = $clog2(MAG_W);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(65);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_SIGN,
    ST_READ,
    ST_EMIT,
    ST_ZERO
  } itr_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd;
    logic emit_sign;
    logic emit_zero;
    logic emit_digit;
  } itr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_zero;
    logic negative;
    logic div_last;
    logic quot_zero;
    logic count_full;
    logic count_one;
    logic out_free;
  } itr_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dc;
    dc = (d > DIGIT_W'(35)) ? DIGIT_W'(35) : d;
    if (dc < DIGIT_W'(10)) begin
      return CHAR_ZERO + CHAR_W'(dc);
    end else begin
      return CHAR_A + CHAR_W'(dc - DIGIT_W'(10));
    end
  endfunction

endpackage

### rtl/core/itr_ram.sv
// itr_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module itr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/itr_datapath.sv
// itr_datapath: radix register, bit-serial divider, digit store and output register
// depends on itr_pkg and itr_ram
module itr_datapath
  import itr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [RADIX_W-1:0]        cfg_data,
  input  logic signed [VALUE_W-1:0] value,
  input  itr_cmd_t                  cmd,
  output itr_status_t               status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         character,
  output logic                      last
);

  logic [RADIX_W-1:0]  radix;
  logic [RADIX_W-1:0]  base;
  logic                negative;
  logic [MAG_W-1:0]    mag;
  logic [DIGIT_W-1:0]  rem;
  logic [BITCNT_W-1:0] bitcnt;
  logic [DCNT_W-1:0]   count;

  logic [VALUE_W-1:0]  abs_val;
  logic [MAG_W-1:0]    mag_init;
  logic [RADIX_W-1:0]  base_clamped;
  logic [DIGIT_W:0]    trial;
  logic                ge;
  logic [DIGIT_W-1:0]  rem_next;
  logic [DIGIT_W-1:0]  rd_digit;

  always_comb begin
    abs_val  = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
    // most negative input has no magnitude in range, clip it
    mag_init = abs_val[VALUE_W-1] ? {MAG_W{1'b1}} : abs_val[MAG_W-1:0];
    if (radix < RADIX_MIN) begin
      base_clamped = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_clamped = RADIX_MAX;
    end else begin
      base_clamped = radix;
    end
    trial    = {rem, mag[MAG_W-1]};
    ge       = trial >= {1'b0, base};
    rem_next = ge ? DIGIT_W'(trial - {1'b0, base}) : trial[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      bitcnt <= '0;
      rem    <= '0;
      mag    <= '0;
    end else if (cmd.load) begin
      negative <= value[VALUE_W-1];
      base     <= base_clamped;
      mag      <= mag_init;
      rem      <= '0;
      bitcnt   <= '0;
      count    <= '0;
    end else if (cmd.div_step) begin
      rem    <= rem_next;
      mag    <= {mag[MAG_W-2:0], ge};
      bitcnt <= bitcnt + BITCNT_W'(1);
    end else if (cmd.store) begin
      rem    <= '0;
      bitcnt <= '0;
      count  <= count + DCNT_W'(1);
    end else if (cmd.emit_digit) begin
      count <= count - DCNT_W'(1);
    end
  end

  itr_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count[DADDR_W-1:0]),
    .wdata (rem),
    .re    (cmd.rd),
    .raddr (DADDR_W'(count - DCNT_W'(1))),
    .rdata (rd_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign) begin
      out_valid <= 1'b1;
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_zero) begin
      out_valid <= 1'b1;
      character <= CHAR_ZERO;
      last      <= 1'b1;
    end else if (cmd.emit_digit) begin
      out_valid <= 1'b1;
      character <= digit_char(rd_digit);
      last      <= (count == DCNT_W'(1));
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.in_zero    = (value == '0);
    status.negative   = negative;
    status.div_last   = (bitcnt == BITCNT_W'(MAG_W - 1));
    status.quot_zero  = (mag == '0);
    status.count_full = (count == DCNT_W'(MAX_DIGITS - 1));
    status.count_one  = (count == DCNT_W'(1));
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

### rtl/core/itr_ctrl.sv
// itr_ctrl: sequencer for conversion, digit storage and character transfer
// depends on itr_pkg
module itr_ctrl
  import itr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  itr_status_t status,
  output itr_cmd_t    cmd
);

  itr_state_t state;
  itr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.in_zero ? ST_ZERO : ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        if (status.quot_zero || status.count_full) begin
          state_next = status.negative ? ST_SIGN : ST_READ;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.count_one ? ST_IDLE : ST_READ;
        end
      end
      ST_ZERO: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV:   cmd.div_step   = 1'b1;
      ST_STORE: cmd.store      = 1'b1;
      ST_SIGN:  cmd.emit_sign  = status.out_free;
      ST_READ:  cmd.rd         = 1'b1;
      ST_EMIT:  cmd.emit_digit = status.out_free;
      ST_ZERO:  cmd.emit_zero  = status.out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### rtl/core/integer_to_radix_digits.sv
// integer_to_radix_digits: top level, signed 64-bit integer to ASCII digits in base 2..36
// depends on itr_pkg, itr_ctrl and itr_datapath
//
// usage:
//   input channel: value with in_valid / in_stall; a transfer happens when in_valid
//   is high and in_stall is low. in_stall is low only while no value is in work.
//   output channel: one character per transfer on character / last with
//   out_valid / out_stall; last marks the final character of a value.
//   configuration: cfg_write loads cfg_data into the radix register (reset 10);
//   write it only while the block is idle. values outside 2..36 act as 2 or 36.
// sequence:
//   each digit comes from 63 steps of a one-bit-per-cycle restoring divider, after
//   which the remainder is stored in the digit RAM. a negative value gets a sign first,
//   and each character is then read back from the digit RAM and sent on.
//   a zero input is sent as the single character 0.
//   the longest item is base 2 with 63 digits.
// reset: rst clears the controller, out_valid and the divider and digit counters, and sets radix to 10.
// stall: a held character stays on the outputs, and the controller waits before
//   loading the next one; the next value can be taken while the last character waits.
module integer_to_radix_digits
  import itr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [RADIX_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         character,
  output logic                      last
);

  itr_cmd_t    cmd;
  itr_status_t status;

  itr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  itr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule
